@@ rtl/mafr_pkg.sv @@
// Shared types and constants for the Mie angular function recurrence core.
// No dependencies; every other file imports this package.
package mafr_pkg;

    // Fixed point format and order range
    localparam int ORDER_LIMIT = 64;
    localparam int FRAC_BITS   = 16;
    localparam int RECIP_BITS  = 24;
    localparam int MU_W        = 18;
    localparam int VAL_W       = 30;
    localparam int ORD_W       = 7;

    // Reset value of the top order register
    localparam logic [ORD_W-1:0] TOP_ORDER_RST = 7'd64;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One queued angle with its clamped order count
    typedef struct packed {
        logic signed [MU_W-1:0] mu;
        logic [ORD_W-1:0]       count;
    } t_job;

    // Front to queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Queue head to back
    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

endpackage

@@ rtl/mafr_if.sv @@
// Valid/ready channel interfaces for the input angle and the per-order result.
// Depends on mafr_pkg for field widths.
interface mafr_in_if import mafr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [MU_W-1:0] mu;

    modport source (output valid, output mu, input ready);
    modport sink   (input valid, input mu, output ready);
endinterface

interface mafr_out_if import mafr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ORD_W-1:0]        order_index;
    logic signed [VAL_W-1:0] pi_value;
    logic signed [VAL_W-1:0] tau_value;
    logic                    last;

    modport source (output valid, output order_index, output pi_value,
                    output tau_value, output last, input ready);
    modport sink   (input valid, input order_index, input pi_value,
                    input tau_value, input last, output ready);
endinterface

@@ rtl/mafr_front.sv @@
// Front end: holds the top order register, accepts angles and tags each
// with its clamped order count. Depends on mafr_pkg and mafr_in_if.
module mafr_front import mafr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [ORD_W-1:0] i_cfg_data,
    mafr_in_if.sink      i_in,
    input  logic         i_q_full,
    output t_push        o_push
);

    logic [ORD_W-1:0] r_top_order;
    logic [ORD_W-1:0] w_count;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_order <= TOP_ORDER_RST;
        end else if (i_cfg_we) begin
            r_top_order <= i_cfg_data;
        end
    end

    // Clamp order count to [2, ORDER_LIMIT]
    always_comb begin
        if (r_top_order < ORD_W'(2)) begin
            w_count = ORD_W'(2);
        end else if (r_top_order > ORD_W'(ORDER_LIMIT)) begin
            w_count = ORD_W'(ORDER_LIMIT);
        end else begin
            w_count = r_top_order;
        end
    end

    // Accept whenever the queue has room
    assign i_in.ready        = !i_q_full;
    assign o_push.valid      = i_in.valid && !i_q_full;
    assign o_push.job.mu     = i_in.mu;
    assign o_push.job.count  = w_count;

endmodule

@@ rtl/mafr_queue.sv @@
// Short job queue decoupling the front end from the recurrence engine.
// Depends on mafr_pkg.
module mafr_queue import mafr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    output t_qhead o_head,
    input  logic   i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full      = (r_cnt == QCNT_W'(QDEPTH));
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

endmodule

@@ rtl/mafr_back.sv @@
// Recurrence engine: steps pi_n and tau_n order by order for one angle,
// sharing one multiply chain, and drives the registered result channel.
// Depends on mafr_pkg and mafr_out_if.
module mafr_back import mafr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qhead      i_head,
    output logic        o_pop,
    mafr_out_if.source  o_out
);

    // Datapath widths
    localparam int SC_W      = MU_W + ORD_W + 1;      // n*mu, (2n-1)*mu
    localparam int PROD_W    = SC_W + VAL_W;          // scaled mu times pi
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int NP2_W     = VAL_W + ORD_W + 1;
    localparam int NP1_W     = VAL_W + ORD_W + 2;
    localparam int DIFF_W    = RND_W + 1;
    localparam int NLIM_BITS = 38;
    localparam int NUM_W     = NLIM_BITS + 2;
    localparam int LO_W      = NUM_W / 2;
    localparam int HI_W      = NUM_W - LO_W;
    localparam int RECIP_W   = RECIP_BITS + 1;
    localparam int PLO_W     = LO_W + RECIP_W;
    localparam int PHI_W     = HI_W + RECIP_W + 1;
    localparam int SUM_W     = PHI_W + LO_W;
    localparam int PRND_W    = SUM_W - RECIP_BITS;
    localparam int RIDX_W    = $clog2(ORDER_LIMIT - 1);
    localparam int RDEPTH    = 2 ** RIDX_W;

    // Constants
    localparam logic signed [PROD_W:0] HALF_F =
        {{(PROD_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [SUM_W:0] HALF_R =
        {{(SUM_W + 1 - RECIP_BITS){1'b0}}, 1'b1, {(RECIP_BITS - 1){1'b0}}};
    localparam logic signed [PRND_W-1:0] SAT_HI =
        {{(PRND_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [PRND_W-1:0] SAT_LO =
        {{(PRND_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] NUM_HI =
        {{(DIFF_W - NLIM_BITS - 1){1'b0}}, 1'b1, {NLIM_BITS{1'b0}}};
    localparam logic signed [DIFF_W-1:0] NUM_LO =
        {{(DIFF_W - NLIM_BITS){1'b1}}, {NLIM_BITS{1'b0}}};
    localparam logic signed [VAL_W-1:0] ONE_V =
        {{(VAL_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [NP1_W-1:0] THREE_ONE =
        {{(NP1_W - FRAC_BITS - 2){1'b0}}, 2'b11, {FRAC_BITS{1'b0}}};

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_NUM  = 3'd3;
    localparam logic [2:0] ST_PART = 3'd4;
    localparam logic [2:0] ST_PN   = 3'd5;
    localparam logic [2:0] ST_MUL3 = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    // Round to nearest, ties away from zero, by FRAC_BITS
    function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] v);
        logic [PROD_W:0]        t;
        logic signed [PROD_W:0] s;
        t = {v[PROD_W-1], v} + HALF_F - {{PROD_W{1'b0}}, v[PROD_W-1]};
        s = $signed(t) >>> FRAC_BITS;
        return s[RND_W-1:0];
    endfunction

    // Same rounding by RECIP_BITS
    function automatic logic signed [PRND_W-1:0] rnd_recip(input logic signed [SUM_W-1:0] v);
        logic [SUM_W:0]        t;
        logic signed [SUM_W:0] s;
        t = {v[SUM_W-1], v} + HALF_R - {{SUM_W{1'b0}}, v[SUM_W-1]};
        s = $signed(t) >>> RECIP_BITS;
        return s[PRND_W-1:0];
    endfunction

    // Clamp to the Q13.16 output range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PRND_W-1:0] v);
        logic signed [PRND_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[VAL_W-1:0];
    endfunction

    // Reciprocal table: entry j holds round(2^RECIP_BITS / (j+1))
    logic [RECIP_W-1:0] w_recip_tab [RDEPTH];
    for (genvar j = 0; j < RDEPTH; j++) begin : g_recip
        localparam longint RV = ((64'sd1 <<< RECIP_BITS) + (j + 1) / 2) / (j + 1);
        assign w_recip_tab[j] = RECIP_W'(RV);
    end

    // Control state
    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [ORD_W-1:0] r_n;
    logic             r_ovalid;

    // Payload state
    logic signed [MU_W-1:0]   r_mu;
    logic [ORD_W-1:0]         r_cnt;
    logic signed [VAL_W-1:0]  r_p1;
    logic signed [VAL_W-1:0]  r_p2;
    logic signed [VAL_W-1:0]  r_pn;
    logic signed [VAL_W-1:0]  r_mop;
    logic signed [SC_W-1:0]   r_a;
    logic signed [SC_W-1:0]   r_b;
    logic signed [NP2_W-1:0]  r_np2;
    logic signed [NP1_W-1:0]  r_np1;
    logic signed [PROD_W-1:0] r_m1;
    logic signed [PROD_W-1:0] r_m3;
    logic signed [NUM_W-1:0]  r_num;
    logic [PLO_W-1:0]         r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic [ORD_W-1:0]         r_oidx;
    logic signed [VAL_W-1:0]  r_opi;
    logic signed [VAL_W-1:0]  r_otau;
    logic                     r_olast;

    // Combinational helpers
    logic                     w_out_free;
    logic                     w_last;
    logic [ORD_W-1:0]         w_odd;
    logic signed [ORD_W:0]    w_odd_s;
    logic signed [ORD_W:0]    w_n_s;
    logic signed [ORD_W+1:0]  w_n1_s;
    logic [ORD_W-1:0]         w_nm2;
    logic [RECIP_W-1:0]       w_recip;
    logic signed [SC_W-1:0]   w_mu_sc;
    logic signed [VAL_W-1:0]  w_mu_v;
    logic signed [RND_W-1:0]  w_r1;
    logic signed [DIFF_W-1:0] w_ndiff;
    logic signed [DIFF_W-1:0] w_nclamp;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [VAL_W-1:0]  w_pn;
    logic signed [RND_W-1:0]  w_r3;
    logic signed [DIFF_W-1:0] w_tdiff;
    logic signed [VAL_W-1:0]  w_tau;

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_last     = (r_n == r_cnt);

    // Order-dependent coefficients
    assign w_odd   = ORD_W'({r_n, 1'b0} - {{ORD_W{1'b0}}, 1'b1});
    assign w_odd_s = {1'b0, w_odd};
    assign w_n_s   = {1'b0, r_n};
    assign w_n1_s  = {2'b00, r_n} + (ORD_W+2)'(1);
    assign w_nm2   = r_n - ORD_W'(2);
    assign w_recip = w_recip_tab[w_nm2[RIDX_W-1:0]];
    assign w_mu_sc = {{(SC_W - MU_W){r_mu[MU_W-1]}}, r_mu};
    assign w_mu_v  = {{(VAL_W - MU_W){r_mu[MU_W-1]}}, r_mu};

    // pi numerator: round((2n-1) mu p1) - n p2, clamped
    assign w_r1    = rnd_frac(r_m1);
    assign w_ndiff = {w_r1[RND_W-1], w_r1}
                   - {{(DIFF_W - NP2_W){r_np2[NP2_W-1]}}, r_np2};
    always_comb begin
        if (w_ndiff > NUM_HI) begin
            w_nclamp = NUM_HI;
        end else if (w_ndiff < NUM_LO) begin
            w_nclamp = NUM_LO;
        end else begin
            w_nclamp = w_ndiff;
        end
    end

    // Recombine the two reciprocal partial products
    assign w_sum = $signed({r_phi, {LO_W{1'b0}}}) + $signed({{(SUM_W - PLO_W){1'b0}}, r_plo});
    assign w_pn  = sat_val(rnd_recip(w_sum));

    // tau: round(b * mop) - np1, saturated
    assign w_r3    = rnd_frac(r_m3);
    assign w_tdiff = {w_r3[RND_W-1], w_r3}
                   - {{(DIFF_W - NP1_W){r_np1[NP1_W-1]}}, r_np1};
    assign w_tau   = sat_val({{(PRND_W - DIFF_W){w_tdiff[DIFF_W-1]}}, w_tdiff});

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = (r_n <= ORD_W'(2)) ? ST_MUL3 : ST_MUL1;
            ST_MUL1: n_state = ST_NUM;
            ST_NUM:  n_state = ST_PART;
            ST_PART: n_state = ST_PN;
            ST_PN:   n_state = ST_MUL3;
            ST_MUL3: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last ? ST_IDLE : ST_PREP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_n <= ORD_W'(1);
            end else if (r_state == ST_EMIT && w_out_free) begin
                r_n <= r_n + ORD_W'(1);
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers, one step per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    r_mu  <= i_head.job.mu;
                    r_cnt <= i_head.job.count;
                end
            end
            ST_PREP: begin
                if (r_n == ORD_W'(1)) begin
                    // order 1: pi = 1, tau = mu
                    r_b   <= w_mu_sc;
                    r_mop <= ONE_V;
                    r_np1 <= '0;
                    r_pn  <= ONE_V;
                end else if (r_n == ORD_W'(2)) begin
                    // order 2: pi = 3mu, tau = 6mu^2 - 3
                    r_b   <= w_mu_sc * $signed(SC_W'(6));
                    r_mop <= w_mu_v;
                    r_np1 <= THREE_ONE;
                    r_pn  <= w_mu_v * $signed(VAL_W'(3));
                end else begin
                    r_a   <= w_odd_s * r_mu;
                    r_b   <= w_n_s * r_mu;
                    r_np2 <= w_n_s * r_p2;
                    r_np1 <= w_n1_s * r_p1;
                end
            end
            ST_MUL1: r_m1 <= r_a * r_p1;
            ST_NUM:  r_num <= w_nclamp[NUM_W-1:0];
            ST_PART: begin
                r_plo <= r_num[LO_W-1:0] * w_recip;
                r_phi <= $signed(r_num[NUM_W-1:LO_W]) * $signed({1'b0, w_recip});
            end
            ST_PN: begin
                r_pn  <= w_pn;
                r_mop <= w_pn;
            end
            ST_MUL3: r_m3 <= r_b * r_mop;
            ST_EMIT: begin
                if (w_out_free) begin
                    r_p2    <= r_p1;
                    r_p1    <= r_pn;
                    r_oidx  <= r_n;
                    r_opi   <= r_pn;
                    r_otau  <= w_tau;
                    r_olast <= w_last;
                end
            end
            default: ;
        endcase
    end

    // Result channel
    assign o_out.valid       = r_ovalid;
    assign o_out.order_index = r_oidx;
    assign o_out.pi_value    = r_opi;
    assign o_out.tau_value   = r_otau;
    assign o_out.last        = r_olast;

endmodule

@@ rtl/mie_angular_function_recursion_core.sv @@
// Top level of the Mie angular function recurrence core: front end, job
// queue and recurrence engine. Depends on mafr_pkg, mafr_if and submodules.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        mu (Q1.16)
//   o_out     out  valid/ready        order_index, pi_value, tau_value, last
//   i_cfg     in   i_cfg_we           i_cfg_data = top order count
//
// One angle yields one result per order up to the top order count (clamped
// to 2..64). Orders 1 and 2 pass through the prep, tau multiply and emit
// steps; higher orders add the pi multiply, numerator, partial product and
// pi steps. The engine ends one angle before it takes the next. Reset is
// synchronous and active low; it sets the top order count to 64 and empties
// the queue. The queue holds two angles, so input is taken while the engine
// works; a stalled result holds the engine in its emit step without losing
// anything.
module mie_angular_function_recursion_core import mafr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ORD_W-1:0] i_cfg_data,
    mafr_in_if.sink          i_in,
    mafr_out_if.source       o_out
);

    t_push  w_push;
    t_qhead w_head;
    logic   w_q_full;
    logic   w_pop;

    mafr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push)
    );

    mafr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    mafr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
